// ===== rtl/rsd_pkg.sv =====
// ---------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the radix digit unit
// Widths of the ports, configuration reset values, register indexes and the
// beat types that travel between the front end, the queues and the back end.
// ---------------------------------------------------------------------------
package rsd_pkg;

    // Field widths
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_ADDR_W  = 2;
    localparam int NUM_SYMBOLS = 16;
    localparam int SYM_IDX_W   = 4;
    localparam int SYMS_W      = 2 * CFG_W;

    // Default largest radix
    localparam int MAX_RADIX_DEF = 16;

    // Digit stack: one digit per bit of the magnitude at most
    localparam int STACK_DEPTH = VALUE_W;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = STACK_IDX_W + 1;

    // Divider: quotient bits resolved per cycle, cycles per digit
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    // Queue depth between the sides
    localparam int QUEUE_DEPTH = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYMBOLS_LO = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SYMBOLS_HI = 2'd2;

    // Reset values
    localparam logic [RADIX_W-1:0] RADIX_RST      = 5'd10;
    localparam logic [CFG_W-1:0]   SYMBOLS_LO_RST = 64'h3736353433323130;
    localparam logic [CFG_W-1:0]   SYMBOLS_HI_RST = 64'h0;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    // Configuration seen by the back end
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [SYMS_W-1:0]  symbols;
    } cfg_t;

    // Classified item in the work queue
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    // Character beat in the result queue
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

endpackage

// ===== rtl/signed_int_to_radix_digits_unit.sv =====
// ---------------------------------------------------------------------------
// signed_int_to_radix_digits_unit: signed integer to text in any radix
// Converts each 32-bit signed value into its characters in the configured
// radix, with a leading minus sign for negatives.
// ---------------------------------------------------------------------------
// A value is converted in the back end one digit at a time: each digit comes
// from the shared divider, which resolves eight quotient bits per cycle, and
// each character then enters the result queue once that queue is not full.
// The front end takes the next value and the result queue holds finished
// characters while the divider works. A value may be pushed from the clock
// edge that follows a configuration write; if the symbol set is unusable,
// values are taken and produce no characters.
// ---------------------------------------------------------------------------
module signed_int_to_radix_digits_unit
    import rsd_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_W-1:0]    value,
    output logic                  empty,
    input  logic                  pop,
    output logic [CHAR_W-1:0]     out_char,
    output logic                  last
);

    cfg_t       cfg;
    item_t      fq_wr_item;
    item_t      fq_rd_item;
    logic       fq_push;
    logic       fq_pop;
    logic       fq_full;
    logic       fq_empty;
    char_beat_t oq_wr_beat;
    char_beat_t oq_rd_beat;
    logic       oq_push;
    logic       oq_full;

    // Front end: configuration and classification
    rsd_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .value     (value),
        .full      (full),
        .q_full    (fq_full),
        .q_push    (fq_push),
        .q_item    (fq_wr_item),
        .cfg       (cfg)
    );

    // Work queue between the two sides
    rsd_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_wr_item),
        .rd_en   (fq_pop),
        .rd_data (fq_rd_item),
        .full    (fq_full),
        .empty   (fq_empty)
    );

    // Back end: division and emission
    rsd_back #(
        .MAX_RADIX (MAX_RADIX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (fq_empty),
        .q_item  (fq_rd_item),
        .q_pop   (fq_pop),
        .o_full  (oq_full),
        .o_push  (oq_push),
        .o_beat  (oq_wr_beat)
    );

    // Result queue towards the consumer
    rsd_fifo #(
        .WIDTH ($bits(char_beat_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_wr_beat),
        .rd_en   (pop),
        .rd_data (oq_rd_beat),
        .full    (oq_full),
        .empty   (empty)
    );

    assign out_char = oq_rd_beat.ch;
    assign last     = oq_rd_beat.last;

endmodule

// ===== rtl/rsd_fifo.sv =====
// ---------------------------------------------------------------------------
// rsd_fifo: small synchronous queue
// Register-based first-in first-out store with full and empty flags. A beat
// may be written and read in the same cycle.
// ---------------------------------------------------------------------------
module rsd_fifo
    import rsd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      rd_ptr_reg;
    logic             do_wr;
    logic             do_rd;

    // Status flags from the pointer difference
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg[AW-1:0]];

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

endmodule

// ===== rtl/rsd_front.sv =====
// ---------------------------------------------------------------------------
// rsd_front: configuration and item classification
// Holds the configuration registers and a registered check of the symbol
// set. Accepted values are split into sign and unsigned magnitude and passed
// to the work queue; values seen under an unusable symbol set are dropped.
// ---------------------------------------------------------------------------
module rsd_front
    import rsd_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  push,
    input  logic [VALUE_W-1:0]    value,
    output logic                  full,
    input  logic                  q_full,
    output logic                  q_push,
    output item_t                 q_item,
    output cfg_t                  cfg
);

    logic [RADIX_W-1:0] radix_reg;
    logic [CFG_W-1:0]   symbols_lo_reg;
    logic [CFG_W-1:0]   symbols_hi_reg;
    logic               cfg_ok_reg;
    logic               cfg_ok_next;
    logic               stg_busy_reg;
    logic               stg_busy_next;
    item_t              stg_item_reg;
    logic               accept;
    logic               drain;
    logic [SYMS_W-1:0]  syms;

    assign syms = {symbols_hi_reg, symbols_lo_reg};
    assign cfg.radix   = radix_reg;
    assign cfg.symbols = syms;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RST;
            symbols_lo_reg <= SYMBOLS_LO_RST;
            symbols_hi_reg <= SYMBOLS_HI_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_RADIX:      radix_reg      <= cfg_wdata[RADIX_W-1:0];
                REG_SYMBOLS_LO: symbols_lo_reg <= cfg_wdata;
                REG_SYMBOLS_HI: symbols_hi_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Symbol set check: radix in range, no reserved or repeated symbol
    always_comb
    begin
        cfg_ok_next = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            if (RADIX_W'(i) < radix_reg)
            begin
                if (syms[i*CHAR_W +: CHAR_W] == CH_NUL   ||
                    syms[i*CHAR_W +: CHAR_W] == CH_PLUS  ||
                    syms[i*CHAR_W +: CHAR_W] == CH_MINUS)
                begin
                    cfg_ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if (RADIX_W'(j) < radix_reg &&
                        syms[j*CHAR_W +: CHAR_W] == syms[i*CHAR_W +: CHAR_W])
                    begin
                        cfg_ok_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ok_reg <= 1'b0;
        end
        else
        begin
            cfg_ok_reg <= cfg_ok_next;
        end
    end

    // Staging register: a beat leaves towards the queue or is dropped
    assign drain         = stg_busy_reg && (!cfg_ok_reg || !q_full);
    assign full          = stg_busy_reg && !drain;
    assign accept        = push && !full;
    assign stg_busy_next = accept || (stg_busy_reg && !drain);
    assign q_push        = stg_busy_reg && cfg_ok_reg && !q_full;
    assign q_item        = stg_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_busy_reg <= 1'b0;
        end
        else
        begin
            stg_busy_reg <= stg_busy_next;
        end
    end

    // Sign and magnitude; the most negative value keeps 2^31 as magnitude
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_item_reg.neg <= value[VALUE_W-1];
            stg_item_reg.mag <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
        end
    end

endmodule

// ===== rtl/rsd_back.sv =====
// ---------------------------------------------------------------------------
// rsd_back: digit generation and character output
// Divides the magnitude repeatedly by the radix, eight quotient bits a
// cycle, stacks the remainders, then emits the sign and the digit symbols
// most significant first into the result queue.
// ---------------------------------------------------------------------------
module rsd_back
    import rsd_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  item_t      q_item,
    output logic       q_pop,
    input  logic       o_full,
    output logic       o_push,
    output char_beat_t o_beat
);

    localparam int RW = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]             state_reg;
    logic [VALUE_W-1:0]     mag_reg;
    logic [RW-1:0]          rem_reg;
    logic [DIV_STEP_W-1:0]  step_reg;
    logic [STACK_CNT_W-1:0] cnt_reg;
    logic                   neg_reg;
    logic [RW-1:0]          stack_reg [STACK_DEPTH];
    logic [VALUE_W-1:0]     div_mag;
    logic [RW-1:0]          div_rem;
    logic [RADIX_W-1:0]     trial;
    logic [STACK_IDX_W-1:0] rd_idx;
    logic [SYM_IDX_W-1:0]   sym_idx;

    // Eight restoring division steps on the narrow remainder
    always_comb
    begin
        div_mag = mag_reg;
        div_rem = rem_reg;
        trial   = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial   = RADIX_W'({div_rem, div_mag[VALUE_W-1]});
            div_mag = {div_mag[VALUE_W-2:0], 1'b0};
            if (trial >= cfg.radix)
            begin
                div_mag[0] = 1'b1;
                div_rem    = RW'(trial - cfg.radix);
            end
            else
            begin
                div_rem = RW'(trial);
            end
        end
    end

    // Output beat: minus sign or the symbol of the top stacked digit
    assign rd_idx  = STACK_IDX_W'(cnt_reg - 1'b1);
    assign sym_idx = SYM_IDX_W'(stack_reg[rd_idx]);
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;
    assign o_push  = ((state_reg == ST_SIGN) || (state_reg == ST_DIGIT)) && !o_full;

    always_comb
    begin
        if (state_reg == ST_SIGN)
        begin
            o_beat.ch   = CH_MINUS;
            o_beat.last = 1'b0;
        end
        else
        begin
            o_beat.ch   = cfg.symbols[{sym_idx, 3'b000} +: CHAR_W];
            o_beat.last = (cnt_reg == STACK_CNT_W'(1));
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        neg_reg   <= q_item.neg;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        rem_reg <= '0;
                        if (div_mag == '0)
                        begin
                            state_reg <= neg_reg ? ST_SIGN : ST_DIGIT;
                        end
                    end
                    else
                    begin
                        rem_reg <= div_rem;
                    end
                end
                ST_SIGN:
                begin
                    if (!o_full)
                    begin
                        state_reg <= ST_DIGIT;
                    end
                end
                ST_DIGIT:
                begin
                    if (!o_full)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == STACK_CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Magnitude shifter and digit stack
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && !q_empty)
        begin
            mag_reg <= q_item.mag;
        end
        else if (state_reg == ST_DIV)
        begin
            mag_reg <= div_mag;
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                stack_reg[cnt_reg[STACK_IDX_W-1:0]] <= div_rem;
            end
        end
    end

    // The stack never holds more digits than the magnitude has bits.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= STACK_CNT_W'(STACK_DEPTH))
        else $error("digit stack overflow");

    // A partial remainder always stays below the radix.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (RADIX_W'(rem_reg) < cfg.radix))
        else $error("remainder not below radix");

    // Output starts only with at least one digit stacked.
    a_emit_digits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SIGN) || (state_reg == ST_DIGIT)) |-> (cnt_reg != '0))
        else $error("emission with empty digit stack");

    // The final digit beat returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (o_push && o_beat.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final character");

endmodule

// ===== tb/signed_int_to_radix_digits_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_radix_digits_unit_tb: self-checking bench of the radix unit
// A driver offers signed values from a queue and a monitor pops character
// beats and compares each one with the text that a local predictor builds
// from its own copy of the radix and symbol registers. Directed values and
// configurations come first, then random segments under several idling
// patterns, and finally a long receiver hold-off that fills the unit.
// ---------------------------------------------------------------------------
module signed_int_to_radix_digits_unit_tb;
    import rsd_pkg::*;

    localparam int RADIX_LIMIT  = MAX_RADIX_DEF;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int REPORT_CAP   = 200;

    // Index that no register answers to
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [VALUE_W-1:0]    value     = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [CHAR_W-1:0]     out_char;
    logic                  last;

    // Local copy of the configuration registers
    logic [RADIX_W-1:0] cur_radix   = RADIX_RST;
    logic [SYMS_W-1:0]  cur_symbols = {SYMBOLS_HI_RST, SYMBOLS_LO_RST};

    logic [VALUE_W-1:0] pending_values[$];
    char_beat_t         expected_chars[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;

    signed_int_to_radix_digits_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .last      (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
            $display("ERROR: %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [CHAR_W-1:0] symbol_at(input int idx);
        return cur_symbols[idx*CHAR_W +: CHAR_W];
    endfunction

    // The set is usable when the radix is in range and its symbols are
    // distinct and free of signs and the zero byte.
    function automatic bit symbols_usable();
        int                n;
        int                i;
        int                j;
        logic [CHAR_W-1:0] c;
        n = int'(cur_radix);
        if (n < 2 || n > RADIX_LIMIT)
            return 1'b0;
        for (i = 0; i < n; i++)
        begin
            c = symbol_at(i);
            if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS)
                return 1'b0;
            for (j = i + 1; j < n; j++)
            begin
                if (symbol_at(j) == c)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Builds the characters of one value and queues them as expected beats.
    function automatic void predict_chars(input logic [VALUE_W-1:0] v);
        logic                 neg;
        logic [VALUE_W-1:0]   mag;
        logic [VALUE_W-1:0]   base;
        logic [SYM_IDX_W-1:0] digit_buf [STACK_DEPTH];
        int                   nd;
        int                   k;
        char_beat_t           beat;
        if (!symbols_usable())
            return;
        neg  = v[VALUE_W-1];
        mag  = neg ? (~v + 1'b1) : v;
        base = VALUE_W'(cur_radix);
        nd   = 0;
        // The unsigned magnitude keeps the most negative value exact.
        do
        begin
            digit_buf[nd] = SYM_IDX_W'(mag % base);
            mag = mag / base;
            nd++;
        end
        while (mag != 0 && nd < STACK_DEPTH);
        if (neg)
        begin
            beat.ch   = CH_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (k = nd - 1; k >= 0; k--)
        begin
            beat.ch   = symbol_at(int'(digit_buf[k]));
            beat.last = (k == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Sixteen distinct bytes, none of them a sign or the zero byte.
    function automatic logic [SYMS_W-1:0] make_symbols();
        logic [SYMS_W-1:0] set;
        logic [CHAR_W-1:0] b;
        bit                used [256];
        int                i;
        for (i = 0; i < NUM_SYMBOLS; i++)
        begin
            do
                b = CHAR_W'($urandom_range(255));
            while (used[b] || b == CH_NUL || b == CH_PLUS || b == CH_MINUS);
            used[b] = 1'b1;
            set[i*CHAR_W +: CHAR_W] = b;
        end
        return set;
    endfunction

    // Mix of small magnitudes, extremes and values of every length.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(5))
            0:
            begin
                v = $urandom_range(40);
                v = v - 32'd20;
            end
            1, 5:
                v = $urandom;
            4:
            begin
                case ($urandom_range(3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            default:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // One register write, then a short pause.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_RADIX:      cur_radix = data[RADIX_W-1:0];
            REG_SYMBOLS_LO: cur_symbols[CFG_W-1:0] = data;
            REG_SYMBOLS_HI: cur_symbols[SYMS_W-1:CFG_W] = data;
            default:        ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Waits until every value is taken and every beat has come, then lets
    // the unit finish any value that produces no characters.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_values.size() != 0 || push || expected_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One random configuration followed by a burst of random values.
    task automatic run_segment(input int n_items);
        int                r;
        int                n;
        int                p;
        int                q;
        int                i;
        logic [SYMS_W-1:0] syms;
        logic [CFG_W-1:0]  rdata;
        wait_idle();
        syms = make_symbols();
        r = $urandom_range(99);
        if (r < 10)
            n = $urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17);
        else if (r < 25)
            n = 2;
        else if (r < 40)
            n = RADIX_LIMIT;
        else
            n = $urandom_range(RADIX_LIMIT, 2);
        // Now and then spoil one symbol in use.
        if (n >= 2 && n <= RADIX_LIMIT && $urandom_range(99) < 12)
        begin
            p = $urandom_range(n - 1);
            case ($urandom_range(3))
                0:       syms[p*CHAR_W +: CHAR_W] = CH_NUL;
                1:       syms[p*CHAR_W +: CHAR_W] = CH_PLUS;
                2:       syms[p*CHAR_W +: CHAR_W] = CH_MINUS;
                default:
                begin
                    q = (p + 1 + $urandom_range(n - 2)) % n;
                    syms[p*CHAR_W +: CHAR_W] = syms[q*CHAR_W +: CHAR_W];
                end
            endcase
        end
        rdata = {$urandom, $urandom};
        rdata[RADIX_W-1:0] = n[RADIX_W-1:0];
        write_reg(REG_RADIX, rdata);
        write_reg(REG_SYMBOLS_LO, syms[CFG_W-1:0]);
        write_reg(REG_SYMBOLS_HI, syms[SYMS_W-1:CFG_W]);
        for (i = 0; i < n_items; i++)
            pending_values.push_back(pick_value());
    endtask

    // Driver: offers the next pending value and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push  <= 1'b0;
            value <= '0;
        end
        else if (!push || !full)
        begin
            if (push)
                predict_chars(value);
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                value <= pending_values.pop_front();
                push  <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Hold-off counter: a long receiver stall once the sequencer asks for it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_served <= 0;
            hold_left   <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each popped beat and decides whether to pop next.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        char_beat_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat, char 0x%02h last %0b",
                                              out_char, last));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h",
                                                  out_char, want.ch));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b on char 0x%02h",
                                                  last, want.last, want.ch));
                end
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Sequencer: reset, directed cases, random phases, pressure, then verdict.
    initial
    begin : sequencer
        int               ph;
        int               s;
        int               i;
        logic [SYMS_W-1:0] syms;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset symbols leave 8 and 9 as zero bytes, so nothing comes out.
        pending_values.push_back(32'd0);
        pending_values.push_back(-32'sd5);

        // Decimal with the full symbol set.
        wait_idle();
        write_reg(REG_SYMBOLS_HI, 64'h3938);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd7);
        pending_values.push_back(-32'sd7);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd1_000_000_000);
        pending_values.push_back(32'h5555_5555);

        // Largest radix.
        wait_idle();
        write_reg(REG_RADIX, 64'd16);
        write_reg(REG_SYMBOLS_HI, 64'h6665_6463_6261_3938);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h0000_ABCD);

        // Binary: the most negative value gives the longest text.
        wait_idle();
        write_reg(REG_RADIX, 64'd2);
        write_reg(REG_SYMBOLS_LO, 64'h3130);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'd0);

        // Radix out of range on either side; upper data bits must be dropped.
        wait_idle();
        write_reg(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE0);
        pending_values.push_back(32'd1);
        wait_idle();
        write_reg(REG_RADIX, 64'd1);
        pending_values.push_back(32'd1);
        wait_idle();
        write_reg(REG_RADIX, 64'd17);
        pending_values.push_back(32'd1);
        wait_idle();
        write_reg(REG_RADIX, 64'h1F);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        pending_values.push_back(32'd1);

        // Plus sign, minus sign and a duplicate among the decimal symbols.
        wait_idle();
        write_reg(REG_RADIX, 64'd10);
        write_reg(REG_SYMBOLS_LO, 64'h3736_3534_2B32_3130);
        write_reg(REG_SYMBOLS_HI, 64'h3938);
        pending_values.push_back(32'd123);
        wait_idle();
        write_reg(REG_SYMBOLS_LO, 64'h3736_3534_3332_312D);
        pending_values.push_back(-32'sd123);
        wait_idle();
        write_reg(REG_SYMBOLS_LO, SYMBOLS_LO_RST);
        write_reg(REG_SYMBOLS_HI, 64'h3038);
        pending_values.push_back(32'd55);

        // Random segments under each idling pattern.
        for (ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 75;
                end
                default:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 33;
                end
            endcase
            for (s = 0; s < 5; s++)
                run_segment(5);
        end

        // Receiver holds off while the sender keeps offering binary values.
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        syms = make_symbols();
        write_reg(REG_RADIX, 64'd2);
        write_reg(REG_SYMBOLS_LO, syms[CFG_W-1:0]);
        write_reg(REG_SYMBOLS_HI, syms[SYMS_W-1:CFG_W]);
        hold_requests = hold_requests + 1;
        for (i = 0; i < 10; i++)
            pending_values.push_back($urandom);

        wait_idle();
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      expected_chars.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
